/* rtl/polyev_pkg.sv */
// ----------------------------------------------------------------------------
// polyev_pkg
// Shared types, codes and saturation helper for the polynomial evaluator.
// ----------------------------------------------------------------------------
package polyev_pkg;

    localparam int DATA_W    = 32;
    localparam int NUM_COEF  = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] TOP_IDX = CFG_IDX_W'(NUM_COEF - 1);

    localparam logic [1:0] CMD_VALUE = 2'd0;
    localparam logic [1:0] CMD_DERIV = 2'd1;
    localparam logic [1:0] CMD_INTEG = 2'd2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DEG = 2'd2;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] x_low;
        logic signed [DATA_W-1:0] x_high;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
    } t_out;

    // Item state carried down the Horner chain: lo lane runs at x_low,
    // hi lane at x_high (used by the integral only).
    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] x_lo;
        logic signed [DATA_W-1:0] x_hi;
        logic signed [DATA_W-1:0] acc_lo;
        logic signed [DATA_W-1:0] acc_hi;
        logic                     ovf;
        logic                     deg_err;
    } t_stage;

    // Coefficient of one Horner step for each mode.
    typedef struct packed {
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] d;
        logic signed [DATA_W-1:0] a;
    } t_coef_sel;

    typedef struct packed {
        logic busy;
        logic dovf_any;
    } t_coef_stat;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     ovf;
    } t_sat;

    // Clamp a wide signed value into 32 bits and flag the clamp.
    function automatic t_sat sat_s32(input logic signed [64:0] v);
        t_sat r;
        if (!v[64] && (|v[63:DATA_W-1])) begin
            r.value = {1'b0, {(DATA_W-1){1'b1}}};
            r.ovf   = 1'b1;
        end else if (v[64] && !(&v[63:DATA_W-1])) begin
            r.value = {1'b1, {(DATA_W-1){1'b0}}};
            r.ovf   = 1'b1;
        end else begin
            r.value = v[DATA_W-1:0];
            r.ovf   = 1'b0;
        end
        return r;
    endfunction

endpackage

/* rtl/polyev_coef.sv */
// ----------------------------------------------------------------------------
// polyev_coef
// Coefficient registers plus the derived derivative and antiderivative sets.
// Antiderivative terms come from a registered reciprocal multiply.
// ----------------------------------------------------------------------------
module polyev_coef import polyev_pkg::*; #(
    parameter int MAX_DEGREE = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]               i_cfg_index,
    input  logic [DATA_W-1:0]                  i_cfg_data,
    output logic [NUM_COEF-1:0][DATA_W-1:0]    o_coef,
    output logic [NUM_COEF-1:0][DATA_W-1:0]    o_deriv,
    output logic [NUM_COEF-1:0][DATA_W-1:0]    o_anti,
    output t_coef_stat                         o_stat
);

    // Scaled reciprocals of the divisors; exact for dividends below 2^31 + 4.
    localparam logic [DATA_W-1:0] RECIP_POW2 = 32'h8000_0000;
    localparam logic [DATA_W-1:0] RECIP_3    = 32'hAAAA_AAAB;
    localparam logic [DATA_W-1:0] RECIP_5    = 32'hCCCC_CCCD;
    localparam logic [DATA_W-1:0] RECIP_7    = 32'h9249_2493;

    logic [NUM_COEF-1:0][DATA_W-1:0] r_coef;
    logic [NUM_COEF-1:0][DATA_W-1:0] r_deriv;
    logic [NUM_COEF-1:0][DATA_W-1:0] r_anti;
    logic [NUM_COEF-1:0]             r_dovf;

    logic                 r_busy;
    logic                 r_phase;
    logic [DATA_W-1:0]    r_num;
    logic [DATA_W-1:0]    r_recip;
    logic [5:0]           r_shift;
    logic [2*DATA_W-1:0]  r_prod;
    logic                 r_neg;
    logic [CFG_IDX_W-1:0] r_slot;

    logic                     w_wr;
    logic signed [35:0]       w_dprod;
    t_sat                     w_dsat;
    logic [2:0]               w_k;
    logic [DATA_W-1:0]        w_mag;
    logic [DATA_W-1:0]        w_recip;
    logic [5:0]               w_shift;
    logic [DATA_W-1:0]        w_quo;
    logic                     w_dovf_any;

    assign w_wr    = i_cfg_valid && !r_busy;
    assign w_dprod = $signed({1'b0, i_cfg_index}) * $signed(i_cfg_data);
    assign w_dsat  = sat_s32(65'(w_dprod));
    assign w_k     = 3'(i_cfg_index + 1'b1);
    assign w_mag   = i_cfg_data[DATA_W-1] ? (~i_cfg_data + 1'b1) : i_cfg_data;
    assign w_quo   = DATA_W'(r_prod >> r_shift);

    // Divide by k as a multiply by a scaled reciprocal and a right shift.
    always_comb begin
        case (w_k)
            3'd2: begin
                w_recip = RECIP_POW2;
                w_shift = 6'd32;
            end
            3'd3: begin
                w_recip = RECIP_3;
                w_shift = 6'd33;
            end
            3'd4: begin
                w_recip = RECIP_POW2;
                w_shift = 6'd33;
            end
            3'd5: begin
                w_recip = RECIP_5;
                w_shift = 6'd34;
            end
            3'd6: begin
                w_recip = RECIP_3;
                w_shift = 6'd34;
            end
            3'd7: begin
                w_recip = RECIP_7;
                w_shift = 6'd34;
            end
            default: begin
                w_recip = RECIP_POW2;
                w_shift = 6'd31;
            end
        endcase
    end

    always_comb begin
        w_dovf_any = 1'b0;
        for (int i = 0; i < NUM_COEF - 1; i++) begin
            if (i < MAX_DEGREE) begin
                w_dovf_any = w_dovf_any | r_dovf[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef  <= '0;
            r_deriv <= '0;
            r_anti  <= '0;
            r_dovf  <= '0;
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
        end else if (w_wr) begin
            r_coef[i_cfg_index] <= i_cfg_data;
            if (i_cfg_index != '0) begin
                r_deriv[3'(i_cfg_index - 1'b1)] <= w_dsat.value;
                r_dovf[3'(i_cfg_index - 1'b1)]  <= w_dsat.ovf;
            end
            if (i_cfg_index != TOP_IDX) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
            end
        end else if (r_busy) begin
            r_phase <= 1'b1;
            if (r_phase) begin
                r_busy         <= 1'b0;
                r_anti[r_slot] <= r_neg ? (~w_quo + 1'b1) : w_quo;
            end
        end
    end

    // Divider operands: rounding offset folded into the dividend.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_num   <= w_mag + {{(DATA_W-2){1'b0}}, w_k[2:1]};
            r_recip <= w_recip;
            r_shift <= w_shift;
            r_neg   <= i_cfg_data[DATA_W-1];
            r_slot  <= CFG_IDX_W'(w_k);
        end else if (r_busy && !r_phase) begin
            r_prod <= r_num * r_recip;
        end
    end

    assign o_coef          = r_coef;
    assign o_deriv         = r_deriv;
    assign o_anti          = r_anti;
    assign o_stat.busy     = r_busy;
    assign o_stat.dovf_any = w_dovf_any;

endmodule

/* rtl/polyev_step.sv */
// ----------------------------------------------------------------------------
// polyev_step
// One Horner step over two lanes: multiply stage, then round, add, saturate.
// ----------------------------------------------------------------------------
module polyev_step import polyev_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_en_mul,
    input  logic      i_en_add,
    input  t_stage    i_d,
    input  t_coef_sel i_coef,
    output t_stage    o_d
);

    localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

    t_stage             r_mul;
    logic signed [63:0] r_p_lo;
    logic signed [63:0] r_p_hi;
    t_stage             r_add;

    logic signed [63:0]       w_rnd_lo;
    logic signed [63:0]       w_rnd_hi;
    logic signed [DATA_W-1:0] w_coef;
    t_sat                     w_sat_lo;
    t_sat                     w_sat_hi;

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_mul  <= i_d;
            r_p_lo <= $signed(i_d.acc_lo) * $signed(i_d.x_lo);
            r_p_hi <= $signed(i_d.acc_hi) * $signed(i_d.x_hi);
        end
    end

    always_comb begin
        unique case (r_mul.cmd)
            CMD_DERIV: w_coef = i_coef.d;
            CMD_INTEG: w_coef = i_coef.a;
            default:   w_coef = i_coef.c;
        endcase
    end

    // Round half up, then add the coefficient.
    assign w_rnd_lo = (r_p_lo + RND_HALF) >>> FRAC_BITS;
    assign w_rnd_hi = (r_p_hi + RND_HALF) >>> FRAC_BITS;
    assign w_sat_lo = sat_s32(65'(w_rnd_lo) + 65'(w_coef));
    assign w_sat_hi = sat_s32(65'(w_rnd_hi) + 65'(w_coef));

    always_ff @(posedge i_clk) begin
        if (i_en_add) begin
            r_add.cmd     <= r_mul.cmd;
            r_add.x_lo    <= r_mul.x_lo;
            r_add.x_hi    <= r_mul.x_hi;
            r_add.deg_err <= r_mul.deg_err;
            r_add.acc_lo  <= w_sat_lo.value;
            r_add.acc_hi  <= w_sat_hi.value;
            r_add.ovf     <= r_mul.ovf | w_sat_lo.ovf
                             | ((r_mul.cmd == CMD_INTEG) & w_sat_hi.ovf);
        end
    end

    assign o_d = r_add;

endmodule

/* rtl/polynomial_evaluator.sv */
// ----------------------------------------------------------------------------
// polynomial_evaluator
// Signed Q16.16 polynomial value, derivative and definite integral by Horner.
// ----------------------------------------------------------------------------
// Takes one point per clock, unless a stall or a coefficient update holds
// input ready low, and returns one result per point, in order, through an
// entry register, a multiply stage and an add/saturate stage per Horner step,
// and an output register that also forms F(x_high)-F(x_low) for the integral.
// Bubbles are squeezed out, so a stalled output only stops the stages
// behind a full one. Each write to coef_0..coef_6 starts a reciprocal
// multiply for the antiderivative term; both ready outputs stay low while it
// runs. A write to coef_7 starts no multiply.
// ----------------------------------------------------------------------------
module polynomial_evaluator import polyev_pkg::*; #(
    parameter int MAX_DEGREE = 7,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    localparam int NST = 2 * MAX_DEGREE + 2;

    logic [NUM_COEF-1:0][DATA_W-1:0] w_coef;
    logic [NUM_COEF-1:0][DATA_W-1:0] w_deriv;
    logic [NUM_COEF-1:0][DATA_W-1:0] w_anti;
    t_coef_stat                      w_stat;

    logic [NST-1:0] r_v;
    logic [NST:0]   w_en;
    logic           w_acc;
    t_stage         r_s0;
    t_stage         w_chain [MAX_DEGREE+1];
    t_out           r_out;
    t_stage         w_last;
    t_sat           w_diff;
    logic           w_top_nz;

    polyev_coef #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (w_coef),
        .o_deriv     (w_deriv),
        .o_anti      (w_anti),
        .o_stat      (w_stat)
    );

    // A stage may load when empty or when the one after it moves.
    always_comb begin
        w_en[NST] = i_out_ready;
        for (int s = NST - 1; s >= 0; s--) begin
            w_en[s] = !r_v[s] || w_en[s+1];
        end
    end

    assign o_in_ready  = w_en[0] && !w_stat.busy;
    assign o_cfg_ready = !w_stat.busy;
    assign w_acc       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= w_acc;
            end
            for (int s = 1; s < NST; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    assign w_top_nz = (w_coef[MAX_DEGREE] != '0);

    // Entry: seed both lanes with the top coefficient of the chosen set (zero for the derivative).
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0.cmd     <= i_in.cmd;
            r_s0.x_lo    <= i_in.x_low;
            r_s0.x_hi    <= i_in.x_high;
            r_s0.ovf     <= (i_in.cmd == CMD_DERIV) && w_stat.dovf_any;
            r_s0.deg_err <= (i_in.cmd == CMD_INTEG) && w_top_nz;
            unique case (i_in.cmd)
                CMD_DERIV: begin
                    r_s0.acc_lo <= '0;
                    r_s0.acc_hi <= '0;
                end
                CMD_INTEG: begin
                    r_s0.acc_lo <= w_anti[MAX_DEGREE];
                    r_s0.acc_hi <= w_anti[MAX_DEGREE];
                end
                default: begin
                    r_s0.acc_lo <= w_coef[MAX_DEGREE];
                    r_s0.acc_hi <= w_coef[MAX_DEGREE];
                end
            endcase
        end
    end

    assign w_chain[0] = r_s0;

    for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_step
        t_coef_sel w_sel;
        assign w_sel.c = w_coef[MAX_DEGREE-1-k];
        assign w_sel.d = w_deriv[MAX_DEGREE-1-k];
        assign w_sel.a = w_anti[MAX_DEGREE-1-k];

        polyev_step #(
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .i_clk    (i_clk),
            .i_en_mul (w_en[1+2*k]),
            .i_en_add (w_en[2+2*k]),
            .i_d      (w_chain[k]),
            .i_coef   (w_sel),
            .o_d      (w_chain[k+1])
        );
    end

    assign w_last = w_chain[MAX_DEGREE];
    assign w_diff = sat_s32(65'(w_last.acc_hi) - 65'(w_last.acc_lo));

    always_ff @(posedge i_clk) begin
        if (w_en[NST-1]) begin
            if (w_last.deg_err) begin
                r_out.value  <= '0;
                r_out.status <= ST_DEG;
            end else if (w_last.cmd == CMD_INTEG) begin
                r_out.value  <= w_diff.value;
                r_out.status <= (w_last.ovf || w_diff.ovf) ? ST_OVF : ST_OK;
            end else begin
                r_out.value  <= w_last.acc_lo;
                r_out.status <= w_last.ovf ? ST_OVF : ST_OK;
            end
        end
    end

    assign o_out_valid = r_v[NST-1];
    assign o_out       = r_out;

endmodule

/* rtl/polyev_checker.sv */
// ----------------------------------------------------------------------------
// polyev_checker
// Port-level checks on the polynomial evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module polyev_checker import polyev_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_out                 o_out,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [CFG_IDX_W-1:0] i_cfg_index
);

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status == ST_OK || o_out.status == ST_OVF
                         || o_out.status == ST_DEG))
        else $error("unknown status code");

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_DEG |-> o_out.value == '0)
        else $error("degree error with nonzero value");

    a_ready_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> o_cfg_ready)
        else $error("input ready while coefficient update busy");

    // A write below the top coefficient starts a divide: drop input ready.
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready && i_cfg_index != TOP_IDX |=> !o_in_ready)
        else $error("input accepted during coefficient update");

endmodule

bind polynomial_evaluator polyev_checker u_polyev_checker (.*);

/* tb/polynomial_evaluator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_evaluator_test
// Self-checking bench for the Q16.16 polynomial value/slope/integral unit.
// ----------------------------------------------------------------------------
// Loads a series of coefficient banks, from reset zeros through all-max and
// all-min extremes to random sets, and streams evaluation points under random
// input gaps and output back-pressure. Every result is compared in order with
// a listed expected value or a saturating Horner calculation kept inside the bench.
// ----------------------------------------------------------------------------
module polynomial_evaluator_test;
    import polyev_pkg::*;

    localparam int DEG         = 7;
    localparam int FRAC        = 16;
    localparam int PIPE_LAT    = 2 * DEG + 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 11;
    localparam int PHASE_PTS   = 50;
    localparam int N_ROWS      = 24;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam longint Q_MAX      = 64'sd2147483647;
    localparam longint Q_MIN      = -64'sd2147483648;
    localparam longint ROUND_HALF = 64'sd1 <<< (FRAC - 1);

    typedef struct {
        int          bank;
        logic [1:0]  cmd;
        logic [31:0] x_lo;
        logic [31:0] x_hi;
        bit          typed;
        logic [31:0] value;
        logic [1:0]  status;
    } t_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in                  i_in        = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out                 o_out;
    logic                 o_cfg_ready;

    longint coef_q [NUM_COEF];
    t_out   evals_due [$];
    bit     quiet = 1'b0;
    int     mismatches = 0;
    int     cycles = 0;
    int     n_value = 0, n_slope = 0, n_integ = 0, n_sat = 0, n_deg = 0, n_loads = 0;

    // Bank 0 is the reset state; 1 is p(x) = 1 + 2x + 3x^2.
    longint coef_banks [5][NUM_COEF] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0},
        '{64'sh10000, 64'sh20000, 64'sh30000, 0, 0, 0, 0, 0},
        '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX},
        '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN},
        '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0}
    };

    t_row dir_rows [N_ROWS] = '{
        '{0, CMD_VALUE, 32'h7fff_ffff, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{0, CMD_DERIV, 32'h8000_0000, 32'hffff_ffff, 1'b1, 32'h0000_0000, ST_OK},
        '{0, CMD_INTEG, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'h0000_0000, ST_OK},
        '{0, CMD_SPARE, 32'h0000_0000, 32'hffff_ffff, 1'b1, 32'h0000_0000, ST_OK},
        '{1, CMD_VALUE, 32'h0000_0000, 32'h7fff_ffff, 1'b1, 32'h0001_0000, ST_OK},
        '{1, CMD_DERIV, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0002_0000, ST_OK},
        '{1, CMD_VALUE, 32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
        '{1, CMD_DERIV, 32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
        '{1, CMD_INTEG, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'h0, ST_OK},
        '{1, CMD_INTEG, 32'h0002_0000, 32'hffff_0000, 1'b0, 32'h0, ST_OK},
        '{1, CMD_SPARE, 32'hffff_8000, 32'h1234_5678, 1'b0, 32'h0, ST_OK},
        '{1, CMD_VALUE, 32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
        '{1, CMD_VALUE, 32'hffff_ffff, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
        '{2, CMD_VALUE, 32'h7fff_ffff, 32'h0000_0000, 1'b1, 32'h7fff_ffff, ST_OVF},
        '{2, CMD_VALUE, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h7fff_ffff, ST_OK},
        '{2, CMD_INTEG, 32'h0000_0000, 32'h0001_0000, 1'b1, 32'h0000_0000, ST_DEG},
        '{2, CMD_DERIV, 32'h7fff_ffff, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
        '{3, CMD_VALUE, 32'h7fff_ffff, 32'h0000_0000, 1'b1, 32'h8000_0000, ST_OVF},
        '{3, CMD_INTEG, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'h0000_0000, ST_DEG},
        '{3, CMD_DERIV, 32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
        '{4, CMD_INTEG, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0, ST_OK},
        '{4, CMD_INTEG, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0, ST_OK},
        '{4, CMD_DERIV, 32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
        '{4, CMD_SPARE, 32'hffff_ffff, 32'h0000_0000, 1'b0, 32'h0, ST_OK}
    };

    polynomial_evaluator #(
        .MAX_DEGREE (DEG),
        .FRAC_BITS  (FRAC)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ---------------- saturating Horner arithmetic ----------------

    function automatic longint clamp32(input longint v, inout bit ovf);
        if (v > Q_MAX) begin
            ovf = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            ovf = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    // Q16.16 product, round to nearest with ties toward plus infinity.
    function automatic longint q_mul(input longint a, input longint b);
        return (a * b + ROUND_HALF) >>> FRAC;
    endfunction

    function automatic longint horner_q(input longint c [NUM_COEF], input int deg,
                                        input longint x, inout bit ovf);
        longint acc;
        acc = c[deg];
        for (int k = deg - 1; k >= 0; k--)
            acc = clamp32(q_mul(acc, x) + c[k], ovf);
        return acc;
    endfunction

    // Round to nearest, ties away from zero.
    function automatic longint div_near(input longint v, input longint k);
        longint m, q;
        m = (v < 0) ? -v : v;
        q = (2 * m + k) / (2 * k);
        return (v < 0) ? -q : q;
    endfunction

    function automatic t_out eval_point(input t_in pt);
        longint terms [NUM_COEF];
        longint v, hi, lo, xl, xh;
        bit     ovf;
        t_out   r;
        ovf      = 1'b0;
        v        = 0;
        r.status = ST_OK;
        xl       = longint'($signed(pt.x_low));
        xh       = longint'($signed(pt.x_high));
        for (int i = 0; i < NUM_COEF; i++)
            terms[i] = 0;
        case (pt.cmd)
            CMD_DERIV: begin
                for (int i = 0; i < DEG; i++)
                    terms[i] = clamp32(longint'(i + 1) * coef_q[i + 1], ovf);
                v = horner_q(terms, DEG - 1, xl, ovf);
            end
            CMD_INTEG: begin
                if (coef_q[DEG] != 0) begin
                    r.status = ST_DEG;
                end else begin
                    for (int i = 1; i <= DEG; i++)
                        terms[i] = div_near(coef_q[i - 1], longint'(i));
                    hi = horner_q(terms, DEG, xh, ovf);
                    lo = horner_q(terms, DEG, xl, ovf);
                    v  = clamp32(hi - lo, ovf);
                end
            end
            default: begin
                v = horner_q(coef_q, DEG, xl, ovf);
            end
        endcase
        if (r.status == ST_OK && ovf)
            r.status = ST_OVF;
        r.value = v[31:0];
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic longint rand_small(input int span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    function automatic longint rand_full();
        return longint'($signed($urandom()));
    endfunction

    function automatic longint rand_coef(input int profile);
        case (profile)
            0: return rand_small(32'h4_0000);
            1: begin
                case ($urandom_range(2))
                    0: return 0;
                    1: return rand_small(32'h4_0000);
                    default: return rand_full();
                endcase
            end
            default: return rand_full();
        endcase
    endfunction

    // Drop valid after the last beat and hold until every result is back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (evals_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_coefs(input longint vals [NUM_COEF]);
        for (int i = 0; i < NUM_COEF; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= vals[i][31:0];
            do @(posedge i_clk); while (!o_cfg_ready);
            coef_q[i] = vals[i];
        end
        i_cfg_valid <= 1'b0;
        n_loads++;
    endtask

    task automatic send_point(input t_in pt, input bit typed, input t_out typed_res);
        if (!quiet) begin
            while ($urandom_range(99) < 14) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in       <= pt;
        do @(posedge i_clk); while (!o_in_ready);
        evals_due.push_back(typed ? typed_res : eval_point(pt));
        case (pt.cmd)
            CMD_DERIV: n_slope++;
            CMD_INTEG: n_integ++;
            default:   n_value++;
        endcase
    endtask

    // ---------------- output side ----------------

    always @(posedge i_clk)
        i_out_ready <= quiet || ($urandom_range(99) >= 14);

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (evals_due.size() == 0) begin
                $error("result beat with nothing outstanding: value %h status %0d",
                       o_out.value, o_out.status);
                mismatches++;
            end else begin
                want = evals_due.pop_front();
                if (o_out.value !== want.value) begin
                    $error("value: expected %h, got %h", want.value, o_out.value);
                    mismatches++;
                end
                if (o_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out.status);
                    mismatches++;
                end
                if (want.status == ST_OVF) n_sat++;
                if (want.status == ST_DEG) n_deg++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, evals_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        t_in    pt;
        t_out   res;
        longint bank [NUM_COEF];
        int     cur_bank;
        int     profile;
        int     pick;

        for (int i = 0; i < NUM_COEF; i++)
            coef_q[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cur_bank = 0;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].bank != cur_bank) begin
                wait_drained();
                cur_bank = dir_rows[r].bank;
                load_coefs(coef_banks[cur_bank]);
            end
            pt.cmd     = dir_rows[r].cmd;
            pt.x_low   = dir_rows[r].x_lo;
            pt.x_high  = dir_rows[r].x_hi;
            res.value  = dir_rows[r].value;
            res.status = dir_rows[r].status;
            send_point(pt, dir_rows[r].typed, res);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            // Two back-to-back phases run with no gaps or stalls at all.
            quiet   = (ph == 4 || ph == 5);
            profile = $urandom_range(2);
            for (int i = 0; i < NUM_COEF; i++)
                bank[i] = rand_coef(profile);
            if ($urandom_range(1) == 0)
                bank[DEG] = 0;
            load_coefs(bank);
            for (int n = 0; n < PHASE_PTS; n++) begin
                pick = $urandom_range(9);
                pt.cmd = (pick < 3) ? CMD_VALUE : (pick < 6) ? CMD_DERIV :
                         (pick < 9) ? CMD_INTEG : CMD_SPARE;
                pt.x_low  = ($urandom_range(4) == 0) ? $urandom() :
                            32'(rand_small(32'h3_0000));
                pt.x_high = ($urandom_range(4) == 0) ? $urandom() :
                            32'(rand_small(32'h3_0000));
                send_point(pt, 1'b0, '0);
            end
        end
        quiet = 1'b0;

        wait_drained();
        repeat (PIPE_LAT + 6) @(posedge i_clk);

        $display("Checked %0d points: %0d value, %0d slope, %0d integral, over %0d coefficient loads.",
                 n_value + n_slope + n_integ, n_value, n_slope, n_integ, n_loads);
        $display("Of these %0d saturated and %0d integrals were refused for degree.",
                 n_sat, n_deg);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
